// ----- rtl/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and decode functions for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Width of the reported error position
    localparam int INDEX_BITS = 16;

    // Bracket characters
    localparam logic [7:0] CHAR_OPEN_PAREN    = 8'h28;  // (
    localparam logic [7:0] CHAR_CLOSE_PAREN   = 8'h29;  // )
    localparam logic [7:0] CHAR_OPEN_BRACE    = 8'h7B;  // {
    localparam logic [7:0] CHAR_CLOSE_BRACE   = 8'h7D;  // }
    localparam logic [7:0] CHAR_OPEN_BRACKET  = 8'h5B;  // [
    localparam logic [7:0] CHAR_CLOSE_BRACKET = 8'h5D;  // ]

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_EMPTY    = 3'd1,
        VERDICT_PAREN    = 3'd2,
        VERDICT_BRACE    = 3'd3,
        VERDICT_BRACKET  = 3'd4,
        VERDICT_UNCLOSED = 3'd5,
        VERDICT_OVERFLOW = 3'd6
    } verdict_t;

    // Bracket kind codes held on the stack
    typedef enum logic [1:0] {
        KIND_PAREN   = 2'd0,
        KIND_BRACE   = 2'd1,
        KIND_BRACKET = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Shift control for the row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

    function automatic kind_t opener_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CHAR_OPEN_PAREN:   k = KIND_PAREN;
            CHAR_OPEN_BRACE:   k = KIND_BRACE;
            CHAR_OPEN_BRACKET: k = KIND_BRACKET;
            default:           k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t closer_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CHAR_CLOSE_PAREN:   k = KIND_PAREN;
            CHAR_CLOSE_BRACE:   k = KIND_BRACE;
            CHAR_CLOSE_BRACKET: k = KIND_BRACKET;
            default:            k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Mismatch code depends on the closer that failed to match
    function automatic verdict_t mismatch_verdict(input kind_t k);
        verdict_t v;
        case (k)
            KIND_PAREN:   v = VERDICT_PAREN;
            KIND_BRACE:   v = VERDICT_BRACE;
            KIND_BRACKET: v = VERDICT_BRACKET;
            default:      v = VERDICT_OK;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/bbc_cell.sv -----
// ----------------------------------------------------------------------------
// bbc_cell
// One stack cell: holds a bracket kind, loads from above on push, below on pop.
// ----------------------------------------------------------------------------
module bbc_cell
    import bbc_pkg::*;
(
    input  logic        clk,
    input  shift_ctrl_t ctrl,
    input  kind_t       from_above,
    input  kind_t       from_below,
    output kind_t       kind
);

    kind_t kind_reg;
    kind_t kind_next;

    // Shift direction select
    always_comb
    begin
        kind_next = kind_reg;
        if (ctrl.push)
        begin
            kind_next = from_above;
        end
        else if (ctrl.pop)
        begin
            kind_next = from_below;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

// ----- rtl/bbc_stack.sv -----
// ----------------------------------------------------------------------------
// bbc_stack
// Shifting stack built as a row of cells; cell 0 is always the top.
// ----------------------------------------------------------------------------
module bbc_stack
    import bbc_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  shift_ctrl_t ctrl,
    input  kind_t       push_kind,
    output kind_t       top_kind
);

    kind_t cell_kind [DEPTH];

    // Row of cells, each handing its kind to a neighbour on every shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        kind_t above;
        kind_t below;

        if (i == 0)
        begin : g_first
            assign above = push_kind;
        end
        else
        begin : g_inner_above
            assign above = cell_kind[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign below = KIND_PAREN;
        end
        else
        begin : g_inner_below
            assign below = cell_kind[i+1];
        end

        bbc_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .from_above (above),
            .from_below (below),
            .kind       (cell_kind[i])
        );
    end

    assign top_kind = cell_kind[0];

endmodule

// ----- rtl/bracket_balance_checker.sv -----
// A verdict beat is registered in the output stage, or in the skid stage while the output beat is held.
// One character beat per cycle while char_stall is low; a push or pop shifts the whole
// row of stack cells at once and only cell 0 (the top) is compared.
// Results pass an output register plus a one-entry skid stage.
// Reset (rst_n low, asynchronous) clears fill level, latched error, position
// counter and both output stages; stack cells are not cleared.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streaming balanced-bracket checker with first-error latch and verdict.
// ----------------------------------------------------------------------------
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH   = 64,
    parameter int POSITION_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    output logic                  verdict_valid,
    input  logic                  verdict_stall,
    output logic [2:0]            verdict,
    output logic [INDEX_BITS-1:0] error_index
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);

    // State registers
    logic [FILL_W-1:0]        fill_reg, fill_next;
    verdict_t                 err_reg, err_next;
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [POSITION_BITS-1:0] at_reg, at_next;

    // Output stage and skid stage
    logic                  out_valid_reg, out_valid_next;
    verdict_t              out_verdict_reg;
    logic [INDEX_BITS-1:0] out_index_reg;
    logic                  skid_valid_reg, skid_valid_next;
    verdict_t              skid_verdict_reg;
    logic [INDEX_BITS-1:0] skid_index_reg;

    logic                     accept;
    logic                     stack_full;
    logic                     stack_empty;
    kind_t                    op_kind;
    kind_t                    cl_kind;
    kind_t                    top_kind;
    shift_ctrl_t              ctrl;
    logic                     res_valid;
    verdict_t                 res_verdict;
    logic [POSITION_BITS-1:0] res_pos;
    logic [INDEX_BITS-1:0]    res_index;
    logic                     out_ready;
    logic                     load_out;
    logic                     load_skid;

    assign accept      = char_valid && !char_stall;
    assign stack_full  = (fill_reg == FILL_W'(STACK_DEPTH));
    assign stack_empty = (fill_reg == '0);
    assign op_kind     = opener_kind(char_code);
    assign cl_kind     = closer_kind(char_code);

    bbc_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .ctrl      (ctrl),
        .push_kind (op_kind),
        .top_kind  (top_kind)
    );

    // Character decode, stack control, error latch and verdict
    always_comb
    begin
        ctrl        = '0;
        fill_next   = fill_reg;
        err_next    = err_reg;
        at_next     = at_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res_verdict = VERDICT_OK;
        res_pos     = '0;
        if (accept)
        begin
            if (err_reg == VERDICT_OK)
            begin
                if (op_kind != KIND_NONE)
                begin
                    if (stack_full)
                    begin
                        err_next = VERDICT_OVERFLOW;
                        at_next  = count_reg;
                    end
                    else
                    begin
                        ctrl.push = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else if (cl_kind != KIND_NONE)
                begin
                    if (stack_empty)
                    begin
                        err_next = VERDICT_EMPTY;
                        at_next  = count_reg;
                    end
                    else if (top_kind == cl_kind)
                    begin
                        ctrl.pop  = 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                    else
                    begin
                        err_next = mismatch_verdict(cl_kind);
                        at_next  = count_reg;
                    end
                end
            end

            // Saturating position
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end

            // End of expression: give verdict and clear
            if (last_char)
            begin
                res_valid = 1'b1;
                if (err_next != VERDICT_OK)
                begin
                    res_verdict = err_next;
                    res_pos     = at_next;
                end
                else if (fill_next != '0)
                begin
                    res_verdict = VERDICT_UNCLOSED;
                    res_pos     = count_reg;
                end
                fill_next  = '0;
                err_next   = VERDICT_OK;
                at_next    = '0;
                count_next = '0;
            end
        end
    end

    // Clamp a wider position to the index width, else zero-extend it
    if (POSITION_BITS > INDEX_BITS)
    begin : g_clamp
        assign res_index = (|res_pos[POSITION_BITS-1:INDEX_BITS]) ? '1
                                                                  : res_pos[INDEX_BITS-1:0];
    end
    else
    begin : g_extend
        assign res_index = INDEX_BITS'(res_pos);
    end

    // Output register with skid stage
    assign out_ready  = !out_valid_reg || !verdict_stall;
    assign char_stall = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                load_out       = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            err_reg        <= VERDICT_OK;
            count_reg      <= '0;
            at_reg         <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            err_reg        <= err_next;
            count_reg      <= count_next;
            at_reg         <= at_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_ready && skid_valid_reg)
        begin
            out_verdict_reg <= skid_verdict_reg;
            out_index_reg   <= skid_index_reg;
        end
        else if (load_out)
        begin
            out_verdict_reg <= res_verdict;
            out_index_reg   <= res_index;
        end
        if (load_skid)
        begin
            skid_verdict_reg <= res_verdict;
            skid_index_reg   <= res_index;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_verdict_reg;
    assign error_index   = out_index_reg;

    // Skid stage only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output stage is empty");

    // Fill level never exceeds the stack depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    // Last character clears the expression state
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_char) |=>
            (fill_reg == '0 && count_reg == '0 && err_reg == VERDICT_OK))
        else $error("expression state not cleared after last character");

    // First error stays latched within an expression
    a_error_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_char && err_reg != VERDICT_OK) |=>
            ($stable(err_reg) && $stable(at_reg)))
        else $error("latched error changed mid-expression");

    // A correct verdict carries position zero
    a_ok_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict == VERDICT_OK) |-> (error_index == '0))
        else $error("correct verdict with nonzero index");

endmodule

// ----- bench/bbc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_checker
// Watches the character and verdict channels of the bracket balance checker.
// It keeps its own bracket stack and error latch, predicts one verdict per
// expression and compares every verdict beat with the oldest one due.
// ----------------------------------------------------------------------------
module bbc_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    input  logic                  char_stall,
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    input  logic                  verdict_valid,
    input  logic                  verdict_stall,
    input  logic [2:0]            verdict,
    input  logic [INDEX_BITS-1:0] error_index,
    output int                    fail_count,
    output int                    pending,
    output int                    verdicts_seen,
    output logic [7:0]            codes_seen
);

    typedef struct packed {
        verdict_t              code;
        logic [INDEX_BITS-1:0] idx;
    } verdict_beat_t;

    // Predicted expression state
    kind_t                 open_kinds [STACK_DEPTH];
    int                    fill;
    verdict_t              err_code;
    logic [INDEX_BITS-1:0] err_pos;
    logic [INDEX_BITS-1:0] char_pos;

    verdict_beat_t         verdicts_due [$];

    // Kind of a bracket character, opener or closer alike
    function automatic kind_t char_kind(input logic [7:0] c);
        case (c)
            CHAR_OPEN_PAREN, CHAR_CLOSE_PAREN:     return KIND_PAREN;
            CHAR_OPEN_BRACE, CHAR_CLOSE_BRACE:     return KIND_BRACE;
            CHAR_OPEN_BRACKET, CHAR_CLOSE_BRACKET: return KIND_BRACKET;
            default:                               return KIND_NONE;
        endcase
    endfunction

    task clear_expression;
        fill     = 0;
        err_code = VERDICT_OK;
        err_pos  = '0;
        char_pos = '0;
    endtask

    // Advance the prediction by one accepted character beat
    task scan_char(input logic [7:0] c, input logic l);
        logic [INDEX_BITS-1:0] pos;
        verdict_beat_t         due;
        pos = char_pos;
        if (err_code == VERDICT_OK)
        begin
            case (c)
                CHAR_OPEN_PAREN, CHAR_OPEN_BRACE, CHAR_OPEN_BRACKET:
                begin
                    if (fill >= STACK_DEPTH)
                    begin
                        err_code = VERDICT_OVERFLOW;
                        err_pos  = pos;
                    end
                    else
                    begin
                        open_kinds[fill] = char_kind(c);
                        fill++;
                    end
                end
                CHAR_CLOSE_PAREN, CHAR_CLOSE_BRACE, CHAR_CLOSE_BRACKET:
                begin
                    if (fill == 0)
                    begin
                        err_code = VERDICT_EMPTY;
                        err_pos  = pos;
                    end
                    else if (open_kinds[fill-1] == char_kind(c))
                    begin
                        fill--;
                    end
                    else
                    begin
                        // mismatch code follows the closer, stack untouched
                        case (char_kind(c))
                            KIND_PAREN: err_code = VERDICT_PAREN;
                            KIND_BRACE: err_code = VERDICT_BRACE;
                            default:    err_code = VERDICT_BRACKET;
                        endcase
                        err_pos = pos;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // position saturates, never wraps
        if (char_pos != {INDEX_BITS{1'b1}})
            char_pos = char_pos + 1'b1;

        if (l)
        begin
            if (err_code != VERDICT_OK)
            begin
                due.code = err_code;
                due.idx  = err_pos;
            end
            else if (fill != 0)
            begin
                due.code = VERDICT_UNCLOSED;
                due.idx  = pos;
            end
            else
            begin
                due.code = VERDICT_OK;
                due.idx  = '0;
            end
            verdicts_due.push_back(due);
            clear_expression();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_beat_t due;
        if (!rst_n)
        begin
            clear_expression();
            verdicts_due.delete();
            fail_count    = 0;
            verdicts_seen = 0;
            codes_seen    = '0;
        end
        else
        begin
            // verdict beat: compare with the oldest prediction
            if (verdict_valid && !verdict_stall)
            begin
                verdicts_seen++;
                codes_seen[verdict] = 1'b1;
                if (verdicts_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected verdict beat, expected none, actual %0d/%0d",
                             $time, verdict, error_index);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (verdict !== due.code)
                    begin
                        fail_count++;
                        $display("%0t: verdict expected %0d, actual %0d",
                                 $time, due.code, verdict);
                    end
                    if (error_index !== due.idx)
                    begin
                        fail_count++;
                        $display("%0t: error_index expected %0d, actual %0d",
                                 $time, due.idx, error_index);
                    end
                end
            end

            // character beat
            if (char_valid && !char_stall)
                scan_char(char_code, last_char);
        end
        pending = verdicts_due.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bracket balance checker.
// Directed expressions first, then random expressions (mostly balanced with
// noise, some damaged, deep nests around the stack limit, pure noise) under
// three idling regimes. Checking is done by bbc_checker.
// ----------------------------------------------------------------------------
module tb
    import bbc_pkg::*;
();

    localparam int STACK_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_RUN  = 235;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  char_valid    = 1'b0;
    logic                  char_stall;
    logic [7:0]            char_code     = 8'h00;
    logic                  last_char     = 1'b0;
    logic                  verdict_valid;
    logic                  verdict_stall = 1'b0;
    logic [2:0]            verdict;
    logic [INDEX_BITS-1:0] error_index;

    int         fail_count;
    int         pending;
    int         verdicts_seen;
    logic [7:0] codes_seen;

    int         send_idle = 0;
    int         recv_idle = 0;
    int         beats_sent = 0;
    int         exprs_sent = 0;
    int         quiet_cycles = 0;

    logic [7:0] expr_q [$];
    kind_t      open_trail [$];

    bracket_balance_checker #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (INDEX_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .last_char     (last_char),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict),
        .error_index   (error_index)
    );

    bbc_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .char_code     (char_code),
        .last_char     (last_char),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict),
        .error_index   (error_index),
        .fail_count    (fail_count),
        .pending       (pending),
        .verdicts_seen (verdicts_seen),
        .codes_seen    (codes_seen)
    );

    // Clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk)
        verdict_stall <= ($urandom_range(0, 99) < recv_idle);

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (verdict_valid && !verdict_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    function automatic logic [7:0] bracket_char(input kind_t k, input logic closing);
        case (k)
            KIND_PAREN:   return closing ? CHAR_CLOSE_PAREN : CHAR_OPEN_PAREN;
            KIND_BRACE:   return closing ? CHAR_CLOSE_BRACE : CHAR_OPEN_BRACE;
            KIND_BRACKET: return closing ? CHAR_CLOSE_BRACKET : CHAR_OPEN_BRACKET;
            default:      return 8'h2E;
        endcase
    endfunction

    function automatic kind_t random_kind();
        return kind_t'($urandom_range(0, 2));
    endfunction

    // One character beat; entered and left at a falling edge
    task send_beat(input logic [7:0] c, input logic l);
        while ($urandom_range(0, 99) < send_idle)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= l;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task send_expr;
        int i;
        for (i = 0; i < expr_q.size(); i++)
            send_beat(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
        exprs_sent++;
    endtask

    task send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            expr_q.push_back(s[i]);
        send_expr();
    endtask

    // Hold the sender off until every verdict due has come back
    task drain_verdicts;
        char_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task make_random_expr;
        int         sel;
        int         i;
        int         target;
        kind_t      k;
        logic [7:0] dropped;
        expr_q.delete();
        open_trail.delete();
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            // balanced with noise, sometimes damaged
            target = $urandom_range(1, 24);
            for (i = 0; i < target; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                begin
                    k = random_kind();
                    open_trail.push_back(k);
                    expr_q.push_back(bracket_char(k, 1'b0));
                end
                else if (sel < 7 && open_trail.size() > 0)
                begin
                    k = open_trail.pop_back();
                    expr_q.push_back(bracket_char(k, 1'b1));
                end
                else
                begin
                    expr_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            while (open_trail.size() > 0)
            begin
                k = open_trail.pop_back();
                expr_q.push_back(bracket_char(k, 1'b1));
            end
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                expr_q[$urandom_range(0, expr_q.size() - 1)] =
                    bracket_char(random_kind(), 1'($urandom_range(0, 1)));
            end
            else if (sel < 25 && expr_q.size() > 1)
            begin
                dropped = expr_q.pop_back();
            end
            else if (sel < 30)
            begin
                expr_q.push_front(bracket_char(random_kind(), 1'b1));
            end
        end
        else if (sel < 80)
        begin
            // deep nest around the stack limit
            target = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
            for (i = 0; i < target; i++)
            begin
                k = random_kind();
                open_trail.push_back(k);
                expr_q.push_back(bracket_char(k, 1'b0));
            end
            while (open_trail.size() > 0)
            begin
                k = open_trail.pop_back();
                expr_q.push_back(bracket_char(k, 1'b1));
            end
        end
        else
        begin
            // noise, half of it bracket characters
            target = $urandom_range(1, 12);
            for (i = 0; i < target; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    expr_q.push_back(bracket_char(random_kind(),
                                                  1'($urandom_range(0, 1))));
                else
                    expr_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int start_beats;
        int start_exprs;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed expressions
        send_idle = 24;
        recv_idle = 85;
        send_text("()");
        send_text("{[()]}");
        send_text(")");
        send_text("[)");
        send_text("(}");
        send_text("(]");
        send_text("(");
        send_text("))(");
        expr_q.push_back(8'h00);
        expr_q.push_back(CHAR_OPEN_PAREN);
        expr_q.push_back(8'hFF);
        expr_q.push_back(CHAR_CLOSE_PAREN);
        send_expr();
        send_text("a");
        drain_verdicts();

        // Random expressions under three idling regimes
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 24;
                    recv_idle = 85;
                end
                1:
                begin
                    send_idle = 85;
                    recv_idle = 24;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            start_beats = beats_sent;
            start_exprs = exprs_sent;
            while (beats_sent - start_beats < ITEMS_PER_RUN || exprs_sent - start_exprs < 20)
            begin
                make_random_expr();
                send_expr();
                if ($urandom_range(0, 99) < 6)
                    drain_verdicts();
            end
            drain_verdicts();
        end

        repeat (8) @(negedge clk);

        $display("Sent %0d character beats in %0d expressions over three idling regimes",
                 beats_sent, exprs_sent);
        $display("Verdict beats checked: %0d, verdict codes seen (bit per code): %b",
                 verdicts_seen, codes_seen);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
